[sv/tpm_pkg.sv]
// ----------------------------------------------------------------------------
// tpm_pkg
// Shared types, constants and helpers for the tilt pointer mapper.
// ----------------------------------------------------------------------------
package tpm_pkg;

	localparam int COORD_WIDTH_DEF = 16;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ACCEL  = 3'd0,
		CFG_FILTER = 3'd1,
		CFG_MIN_X  = 3'd2,
		CFG_MAX_X  = 3'd3,
		CFG_MIN_Y  = 3'd4,
		CFG_MAX_Y  = 3'd5
	} cfg_index_t;

	localparam logic [6:0]         ACCEL_RST  = 7'd5;
	localparam logic [13:0]        FILTER_RST = 14'd0;
	localparam logic signed [15:0] MIN_X_RST  = 16'sd0;
	localparam logic signed [15:0] MAX_X_RST  = 16'sd1919;
	localparam logic signed [15:0] MIN_Y_RST  = 16'sd0;
	localparam logic signed [15:0] MAX_Y_RST  = 16'sd1079;

	// input opcodes
	localparam logic OP_SAMPLE    = 1'b0;
	localparam logic OP_CALIBRATE = 1'b1;

	// tilt fold: bytes above the limit wrap to base minus byte
	localparam int TILT_FOLD_LIMIT = 99;
	localparam int TILT_FOLD_BASE  = 100;

	// gain scale acc * 20 / 100 reduces to a divide by five
	localparam int SCALE_NUM   = 20;
	localparam int SCALE_DEN   = 100;
	localparam int SCALE_DIV   = SCALE_DEN / SCALE_NUM;
	localparam int RECIP_SHIFT = 18;
	localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + SCALE_DIV - 1) / SCALE_DIV;

	// datapath widths
	localparam int TILT_W  = 9;   // folded tilt, -155..99
	localparam int DIFF_W  = 10;  // folded minus neutral
	localparam int ABS_W   = 8;   // |diff| <= 254
	localparam int MAG_W   = 15;  // |diff| * acc
	localparam int QUO_W   = 13;  // scaled delta magnitude
	localparam int SQ_W    = 2 * QUO_W;
	localparam int SSQ_W   = SQ_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SQR,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic take;    // latch the incoming item
		logic mul;     // gain multiply
		logic div;     // divide by the scale
		logic sqr;     // deadband and square
		logic commit;  // clamp, update position, load result
	} cmd_t;

	function automatic logic signed [TILT_W-1:0] fold_tilt(input logic [7:0] b);
		logic signed [TILT_W:0] w;
		w = (int'(b) > TILT_FOLD_LIMIT) ?
			(TILT_W+1)'(TILT_FOLD_BASE) - $signed({2'b00, b}) : $signed({2'b00, b});
		return w[TILT_W-1:0];
	endfunction

endpackage

[sv/tpm_ctrl.sv]
// ----------------------------------------------------------------------------
// tpm_ctrl
// Sequencer for the tilt pointer mapper: steps one item through the datapath
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module tpm_ctrl
	import tpm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output tpm_pkg::cmd_t cmd
);

	state_t state_q, state_next;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_next;
			out_valid_q <= cmd.commit | (out_valid_q & out_stall);
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_next = ST_MUL;
			ST_MUL:  state_next = ST_DIV;
			ST_DIV:  state_next = ST_SQR;
			ST_SQR:  state_next = ST_UPD;
			ST_UPD:  if (cmd.commit) state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.take   = (state_q == ST_IDLE) & in_valid;
		cmd.mul    = (state_q == ST_MUL);
		cmd.div    = (state_q == ST_DIV);
		cmd.sqr    = (state_q == ST_SQR);
		// wait for the result register to drain
		cmd.commit = (state_q == ST_UPD) & (~out_valid_q | ~out_stall);
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

[sv/tpm_datapath.sv]
// ----------------------------------------------------------------------------
// tpm_datapath
// Registers, neutral tilt, position state and the scale, square and clamp
// arithmetic of the tilt pointer mapper.
// ----------------------------------------------------------------------------
module tpm_datapath
	import tpm_pkg::*;
#(
	parameter int COORD_WIDTH = tpm_pkg::COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  tpm_pkg::cmd_t cmd,
	input  logic cfg_wr_en,
	input  logic [tpm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tpm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic opcode,
	input  logic payload_present,
	input  logic [7:0] tilt_x,
	input  logic [7:0] tilt_y,
	output logic signed [15:0] pointer_x,
	output logic signed [15:0] pointer_y,
	output logic moved
);

	localparam int SUM_W = ((COORD_WIDTH > SSQ_W) ? COORD_WIDTH : SSQ_W) + 1;
	localparam logic signed [SUM_W-1:0] CMAX =
		SUM_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] CMIN = -CMAX - SUM_W'(1);

	// configuration
	logic [6:0]         accel_q;
	logic [13:0]        filter_q;
	logic signed [15:0] min_x_q, max_x_q, min_y_q, max_y_q;

	// state
	logic signed [TILT_W-1:0]      neutral_x_q, neutral_y_q;
	logic signed [COORD_WIDTH-1:0] pos_x_q, pos_y_q;

	// per item
	logic signed [DIFF_W-1:0] d_x_q, d_y_q;
	logic                     sample_q;
	logic [MAG_W-1:0]         mag_x_s1, mag_y_s1;
	logic                     neg_x_s1, neg_y_s1;
	logic [QUO_W-1:0]         quo_x_s2, quo_y_s2;
	logic                     neg_x_s2, neg_y_s2;
	logic signed [SSQ_W-1:0]  sq_x_s3, sq_y_s3;
	logic                     nz_x_s3, nz_y_s3;

	logic signed [15:0] pointer_x_q, pointer_y_q;
	logic               moved_q;

	logic signed [TILT_W-1:0] fold_x, fold_y;
	logic [DIFF_W-1:0]        abs_x, abs_y;
	logic [2*MAG_W+1:0]       prod_x, prod_y;
	logic [SQ_W-1:0]          sqm_x, sqm_y;
	logic                     do_move;
	logic signed [COORD_WIDTH-1:0] new_x, new_y, next_x, next_y;

	function automatic logic signed [COORD_WIDTH-1:0] place(
		input logic signed [COORD_WIDTH-1:0] p,
		input logic signed [SSQ_W-1:0]       d,
		input logic signed [15:0]            lo,
		input logic signed [15:0]            hi
	);
		logic signed [SUM_W-1:0] v;
		logic signed [SUM_W-1:0] lo_w, hi_w;
		v    = SUM_W'(p) + SUM_W'(d);
		lo_w = SUM_W'(lo);
		hi_w = SUM_W'(hi);
		// upper bound first so the lower bound wins on inverted limits
		if (v > hi_w) v = hi_w;
		if (v < lo_w) v = lo_w;
		if (v > CMAX) v = CMAX;
		if (v < CMIN) v = CMIN;
		return v[COORD_WIDTH-1:0];
	endfunction

	assign fold_x = fold_tilt(tilt_x);
	assign fold_y = fold_tilt(tilt_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q  <= ACCEL_RST;
			filter_q <= FILTER_RST;
			min_x_q  <= MIN_X_RST;
			max_x_q  <= MAX_X_RST;
			min_y_q  <= MIN_Y_RST;
			max_y_q  <= MAX_Y_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_ACCEL:  accel_q  <= cfg_data[6:0];
				CFG_FILTER: filter_q <= cfg_data[13:0];
				CFG_MIN_X:  min_x_q  <= $signed(cfg_data);
				CFG_MAX_X:  max_x_q  <= $signed(cfg_data);
				CFG_MIN_Y:  min_y_q  <= $signed(cfg_data);
				CFG_MAX_Y:  max_y_q  <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// neutral tilt and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neutral_x_q <= '0;
			neutral_y_q <= '0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
		end else begin
			if (cmd.take && opcode == OP_CALIBRATE) begin
				neutral_x_q <= payload_present ? fold_x : '0;
				neutral_y_q <= payload_present ? fold_y : '0;
			end
			if (cmd.commit) begin
				pos_x_q <= next_x;
				pos_y_q <= next_y;
			end
		end
	end

	// latch: swap is identity on x, negate on y
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			d_x_q    <= DIFF_W'(fold_x) - DIFF_W'(neutral_x_q);
			d_y_q    <= DIFF_W'(neutral_y_q) - DIFF_W'(fold_y);
			sample_q <= (opcode == OP_SAMPLE) & payload_present;
		end
	end

	assign abs_x = d_x_q[DIFF_W-1] ? DIFF_W'(-d_x_q) : d_x_q;
	assign abs_y = d_y_q[DIFF_W-1] ? DIFF_W'(-d_y_q) : d_y_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			mag_x_s1 <= MAG_W'(abs_x[ABS_W-1:0] * accel_q);
			mag_y_s1 <= MAG_W'(abs_y[ABS_W-1:0] * accel_q);
			neg_x_s1 <= d_x_q[DIFF_W-1];
			neg_y_s1 <= d_y_q[DIFF_W-1];
		end
	end

	// divide by the scale through the reciprocal
	assign prod_x = (2*MAG_W+2)'(mag_x_s1) * (2*MAG_W+2)'(RECIP_MUL);
	assign prod_y = (2*MAG_W+2)'(mag_y_s1) * (2*MAG_W+2)'(RECIP_MUL);

	always_ff @(posedge clk) begin
		if (cmd.div) begin
			quo_x_s2 <= prod_x[RECIP_SHIFT +: QUO_W];
			quo_y_s2 <= prod_y[RECIP_SHIFT +: QUO_W];
			neg_x_s2 <= neg_x_s1;
			neg_y_s2 <= neg_y_s1;
		end
	end

	assign sqm_x = quo_x_s2 * quo_x_s2;
	assign sqm_y = quo_y_s2 * quo_y_s2;

	// drop deltas inside the deadband
	always_ff @(posedge clk) begin
		if (cmd.sqr) begin
			nz_x_s3 <= {1'b0, quo_x_s2} > filter_q;
			nz_y_s3 <= {1'b0, quo_y_s2} > filter_q;
			if ({1'b0, quo_x_s2} > filter_q)
				sq_x_s3 <= neg_x_s2 ? -$signed({1'b0, sqm_x}) : $signed({1'b0, sqm_x});
			else
				sq_x_s3 <= '0;
			if ({1'b0, quo_y_s2} > filter_q)
				sq_y_s3 <= neg_y_s2 ? -$signed({1'b0, sqm_y}) : $signed({1'b0, sqm_y});
			else
				sq_y_s3 <= '0;
		end
	end

	assign do_move = sample_q & (nz_x_s3 | nz_y_s3);
	assign new_x   = place(pos_x_q, sq_x_s3, min_x_q, max_x_q);
	assign new_y   = place(pos_y_q, sq_y_s3, min_y_q, max_y_q);
	assign next_x  = do_move ? new_x : pos_x_q;
	assign next_y  = do_move ? new_y : pos_y_q;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			pointer_x_q <= 16'(next_x);
			pointer_y_q <= 16'(next_y);
			moved_q     <= do_move;
		end
	end

	assign pointer_x = pointer_x_q;
	assign pointer_y = pointer_y_q;
	assign moved     = moved_q;

endmodule

[sv/tilt_pointer_mapper.sv]
// ----------------------------------------------------------------------------
// tilt_pointer_mapper
// Maps tilt samples to a clamped pointer position; calibrate items set the
// neutral tilt.
// ----------------------------------------------------------------------------
// Flow: each accepted item passes the gain multiply, reciprocal divide,
//   square, and clamp and commit steps before its result is valid.
// Sequencing: the sequencer walks each item through the shared multiply,
//   divide and square steps and takes no new item until the last commits.
// Reset: arst_n clears neutral tilt and position to zero and loads the
//   register defaults; no result is pending after reset.
module tilt_pointer_mapper
	import tpm_pkg::*;
#(
	// pointer position width, 12 to 32 bits
	parameter int COORD_WIDTH = tpm_pkg::COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// configuration write port
	input  logic cfg_wr_en,
	input  logic [tpm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tpm_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input item channel
	input  logic in_valid,
	output logic in_stall,
	input  logic opcode,
	input  logic payload_present,
	input  logic [7:0] tilt_x,
	input  logic [7:0] tilt_y,
	// result item channel
	output logic out_valid,
	input  logic out_stall,
	output logic signed [15:0] pointer_x,
	output logic signed [15:0] pointer_y,
	output logic moved
);

	cmd_t cmd;

	// Sequencer: takes an item in idle, steps it through the datapath,
	// and commits once the result register is free. The result register
	// lets the next item be accepted while a result still waits.
	tpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Datapath: fold and subtract neutral on take, scale by the gain,
	// deadband and square, then clamp and update the position on commit.
	tpm_datapath #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.opcode          (opcode),
		.payload_present (payload_present),
		.tilt_x          (tilt_x),
		.tilt_y          (tilt_y),
		.pointer_x       (pointer_x),
		.pointer_y       (pointer_y),
		.moved           (moved)
	);

endmodule

[tb/sv/tilt_pointer_mapper_test.sv]
// ----------------------------------------------------------------------------
// tilt_pointer_mapper_test
// Self-checking bench for the tilt pointer mapper. A directed table of tilt
// items and register writes runs first, then randomized phases under fresh
// register settings. Every result item is checked against a hand-checked value
// or a cycle-free model of the fold, gain, deadband, square and clamp math.
// ----------------------------------------------------------------------------
module tilt_pointer_mapper_test;
	import tpm_pkg::*;

	// settle time after the last result before touching registers or ending
	localparam int DRAIN_CYCLES = 8;
	// generous cap on the whole run, far above the slowest legal schedule
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 75;
	localparam longint COORD_MAX = (longint'(1) << (COORD_WIDTH_DEF - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;

	// receiver stall patterns
	typedef enum int {
		HOLD_NONE,
		HOLD_HALF,
		HOLD_HEAVY,
		HOLD_PERIODIC
	} hold_mode_t;

	// one result item as the block reports it
	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic               mv;
	} pointer_t;

	// one step of the directed table: a register write or a tilt item
	typedef struct {
		bit                    is_write;
		cfg_index_t            reg_sel;
		logic [CFG_DATA_W-1:0] reg_val;
		logic                  op;
		logic                  pres;
		logic [7:0]            tx;
		logic [7:0]            ty;
		bit                    known;
		logic signed [15:0]    kx;
		logic signed [15:0]    ky;
		logic                  km;
	} step_row_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   opcode = OP_SAMPLE;
	logic                   payload_present = 1'b0;
	logic [7:0]             tilt_x = '0;
	logic [7:0]             tilt_y = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic signed [15:0]     pointer_x;
	logic signed [15:0]     pointer_y;
	logic                   moved;

	// register mirror
	logic [6:0]         gain_reg;
	logic [13:0]        band_reg;
	logic signed [15:0] lo_x;
	logic signed [15:0] hi_x;
	logic signed [15:0] lo_y;
	logic signed [15:0] hi_y;

	// mirrored block state: neutral tilt and pointer position
	longint rest_x;
	longint rest_y;
	longint pos_x;
	longint pos_y;

	// positions still owed by the block, oldest first
	pointer_t pointer_due[$];
	step_row_t plan[$];

	int errors = 0;
	int items_taken = 0;
	int burst_left = 0;

	// side table of a hand-checked result for the item now on the bus
	bit                 row_known = 1'b0;
	logic signed [15:0] row_kx = '0;
	logic signed [15:0] row_ky = '0;
	logic               row_km = 1'b0;

	tilt_pointer_mapper i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.payload_present (payload_present),
		.tilt_x          (tilt_x),
		.tilt_y          (tilt_y),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pointer_x       (pointer_x),
		.pointer_y       (pointer_y),
		.moved           (moved)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ------------------------------------------------------------------
	// pointer math
	// ------------------------------------------------------------------

	// bytes above the fold limit wrap to base minus byte
	function automatic longint fold_raw(input logic [7:0] b);
		longint v;
		v = longint'(b);
		return (v > TILT_FOLD_LIMIT) ? TILT_FOLD_BASE - v : v;
	endfunction

	// gain, scale toward zero, then zero anything inside the deadband
	function automatic longint scaled_delta(input longint d);
		longint r;
		longint f;
		r = (d * longint'(gain_reg) * SCALE_NUM) / SCALE_DEN;
		f = longint'(band_reg);
		if (r <= f && r >= -f)
			r = 0;
		return r;
	endfunction

	function automatic longint signed_sq(input longint d);
		return (d < 0) ? -(d * d) : d * d;
	endfunction

	// upper bound first, lower bound last, then saturate to the coordinate range
	function automatic longint clamp_coord(input longint v, input logic signed [15:0] lo,
			input logic signed [15:0] hi);
		longint c;
		c = v;
		if (c > longint'(hi))
			c = longint'(hi);
		if (c < longint'(lo))
			c = longint'(lo);
		if (c > COORD_MAX)
			c = COORD_MAX;
		if (c < COORD_MIN)
			c = COORD_MIN;
		return c;
	endfunction

	// advance the mirrored state by one accepted item and return its result
	function automatic pointer_t advance_pointer(input logic op, input logic pres,
			input logic [7:0] tx, input logic [7:0] ty);
		pointer_t r;
		longint dx;
		longint dy;
		r.mv = 1'b0;
		if (op == OP_CALIBRATE) begin
			rest_x = pres ? fold_raw(tx) : 0;
			rest_y = pres ? fold_raw(ty) : 0;
		end else if (pres) begin
			// swap sense on the vertical axis: tilting forward moves up
			dx = scaled_delta(fold_raw(tx) - rest_x);
			dy = scaled_delta(rest_y - fold_raw(ty));
			if (dx != 0 || dy != 0) begin
				pos_x = clamp_coord(pos_x + signed_sq(dx), lo_x, hi_x);
				pos_y = clamp_coord(pos_y + signed_sq(dy), lo_y, hi_y);
				r.mv = 1'b1;
			end
		end
		r.px = pos_x[15:0];
		r.py = pos_y[15:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// directed table rows
	// ------------------------------------------------------------------

	function automatic step_row_t reg_row(input cfg_index_t sel, input logic [15:0] v);
		step_row_t s;
		s = '{reg_sel: CFG_ACCEL, default: '0};
		s.is_write = 1'b1;
		s.reg_sel = sel;
		s.reg_val = v;
		return s;
	endfunction

	function automatic step_row_t tilt_row(input logic op, input logic pres,
			input logic [7:0] tx, input logic [7:0] ty);
		step_row_t s;
		s = '{reg_sel: CFG_ACCEL, default: '0};
		s.reg_sel = CFG_ACCEL;
		s.op = op;
		s.pres = pres;
		s.tx = tx;
		s.ty = ty;
		return s;
	endfunction

	function automatic step_row_t known_row(input logic op, input logic pres,
			input logic [7:0] tx, input logic [7:0] ty, input logic signed [15:0] kx,
			input logic signed [15:0] ky, input logic km);
		step_row_t s;
		s = tilt_row(op, pres, tx, ty);
		s.known = 1'b1;
		s.kx = kx;
		s.ky = ky;
		s.km = km;
		return s;
	endfunction

	// ------------------------------------------------------------------
	// drivers; all called and returning at a falling edge
	// ------------------------------------------------------------------

	// drop valid and wait until every owed result has come out
	task automatic settle();
		in_valid <= 1'b0;
		while (pointer_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t sel, input logic [15:0] v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_index <= sel;
		cfg_data <= v;
		case (sel)
			CFG_ACCEL:  gain_reg = v[6:0];
			CFG_FILTER: band_reg = v[13:0];
			CFG_MIN_X:  lo_x = v;
			CFG_MAX_X:  hi_x = v;
			CFG_MIN_Y:  lo_y = v;
			CFG_MAX_Y:  hi_y = v;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// present one item, sometimes idling first at the start of a burst, and hold it
	// until the monitor counts it as taken
	task automatic send_tilt(input logic op, input logic pres, input logic [7:0] tx,
			input logic [7:0] ty, input bit known, input logic signed [15:0] kx,
			input logic signed [15:0] ky, input logic km);
		int gap;
		int seen;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		row_known = known;
		row_kx = kx;
		row_ky = ky;
		row_km = km;
		opcode <= op;
		payload_present <= pres;
		tilt_x <= tx;
		tilt_y <= ty;
		in_valid <= 1'b1;
		seen = items_taken;
		do
			@(negedge clk);
		while (items_taken == seen);
	endtask

	// ------------------------------------------------------------------
	// receiver: stall in segments of random length and pattern
	// ------------------------------------------------------------------
	int stall_left = 0;
	hold_mode_t stall_mode = HOLD_NONE;

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = hold_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(4, 40);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			HOLD_NONE:  out_stall <= 1'b0;
			HOLD_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
			HOLD_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:    out_stall <= stall_left[1];
		endcase
	end

	// ------------------------------------------------------------------
	// monitor: check results first, then queue the prediction for a taken item
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		pointer_t seen;
		pointer_t calc;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pointer_due.size() == 0) begin
					$error("result item with no expectation: x %0d y %0d moved %0b",
						pointer_x, pointer_y, moved);
					errors++;
				end else begin
					seen = pointer_due.pop_front();
					if (seen.px !== pointer_x) begin
						$error("pointer_x: expected %0d, got %0d", $signed(seen.px),
							pointer_x);
						errors++;
					end
					if (seen.py !== pointer_y) begin
						$error("pointer_y: expected %0d, got %0d", $signed(seen.py),
							pointer_y);
						errors++;
					end
					if (seen.mv !== moved) begin
						$error("moved: expected %0b, got %0b", seen.mv, moved);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				// always advance the mirror; a hand-checked row overrides the result
				calc = advance_pointer(opcode, payload_present, tilt_x, tilt_y);
				if (row_known) begin
					calc.px = row_kx;
					calc.py = row_ky;
					calc.mv = row_km;
				end
				pointer_due.push_back(calc);
				items_taken++;
			end
		end
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("simulation failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		step_row_t row;
		int pick;
		int lo_i;
		int hi_i;
		int g;
		int f;
		logic op;
		logic pres;
		logic [7:0] tx;
		logic [7:0] ty;
		logic [7:0] near_x;
		logic [7:0] near_y;
		cfg_index_t lo_sel;
		cfg_index_t hi_sel;

		gain_reg = ACCEL_RST;
		band_reg = FILTER_RST;
		lo_x = MIN_X_RST;
		hi_x = MAX_X_RST;
		lo_y = MIN_Y_RST;
		hi_y = MAX_Y_RST;
		rest_x = 0;
		rest_y = 0;
		pos_x = 0;
		pos_y = 0;
		near_x = '0;
		near_y = '0;

		// defaults after reset: gain 5, no deadband, 1920 x 1080 screen
		// sample without payload leaves everything alone
		plan.push_back(known_row(OP_SAMPLE, 1'b0, 8'd255, 8'd255, 16'sd0, 16'sd0, 1'b0));
		// level tilt: zero delta, no move
		plan.push_back(known_row(OP_SAMPLE, 1'b1, 8'd0, 8'd0, 16'sd0, 16'sd0, 1'b0));
		// largest positive fold pins x at the right edge
		plan.push_back(known_row(OP_SAMPLE, 1'b1, 8'd99, 8'd0, 16'sd1919, 16'sd0, 1'b1));
		// 100 folds to zero, 255 folds to the most negative tilt
		plan.push_back(known_row(OP_SAMPLE, 1'b1, 8'd100, 8'd255, 16'sd1919, 16'sd1079,
			1'b1));
		plan.push_back(known_row(OP_SAMPLE, 1'b1, 8'd255, 8'd0, 16'sd0, 16'sd1079, 1'b1));
		// smallest nonzero delta on both axes
		plan.push_back(tilt_row(OP_SAMPLE, 1'b1, 8'd101, 8'd101));
		// calibrate, then a sample at the neutral tilt does not move
		plan.push_back(known_row(OP_CALIBRATE, 1'b1, 8'd200, 8'd50, 16'sd0, 16'sd1079,
			1'b0));
		plan.push_back(known_row(OP_SAMPLE, 1'b1, 8'd200, 8'd50, 16'sd0, 16'sd1079, 1'b0));
		plan.push_back(tilt_row(OP_SAMPLE, 1'b1, 8'd0, 8'd0));
		// calibrate without payload clears the neutral tilt
		plan.push_back(known_row(OP_CALIBRATE, 1'b0, 8'd255, 8'd255, 16'sd1919, 16'sd1079,
			1'b0));
		plan.push_back(tilt_row(OP_SAMPLE, 1'b1, 8'd3, 8'd97));
		// zero gain freezes the pointer
		plan.push_back(reg_row(CFG_ACCEL, 16'd0));
		plan.push_back(tilt_row(OP_SAMPLE, 1'b1, 8'd99, 8'd155));
		// full gain above 100 with the widest deadband swallows every delta
		plan.push_back(reg_row(CFG_ACCEL, 16'd127));
		plan.push_back(reg_row(CFG_FILTER, 16'd16383));
		plan.push_back(tilt_row(OP_SAMPLE, 1'b1, 8'd255, 8'd99));
		plan.push_back(reg_row(CFG_FILTER, 16'd0));
		plan.push_back(tilt_row(OP_SAMPLE, 1'b1, 8'd255, 8'd99));
		// inverted x bounds: the minimum wins; y spans the whole coordinate range
		plan.push_back(reg_row(CFG_MIN_X, 16'(100)));
		plan.push_back(reg_row(CFG_MAX_X, 16'(-100)));
		plan.push_back(reg_row(CFG_MIN_Y, 16'(-32768)));
		plan.push_back(reg_row(CFG_MAX_Y, 16'(32767)));
		plan.push_back(known_row(OP_SAMPLE, 1'b1, 8'd0, 8'd255, 16'sd100, 16'sd32767, 1'b1));
		plan.push_back(known_row(OP_SAMPLE, 1'b1, 8'd0, 8'd99, 16'sd100, -16'sd32768, 1'b1));
		// deadband edge: a delta equal to the half width is dropped
		plan.push_back(reg_row(CFG_ACCEL, 16'd5));
		plan.push_back(reg_row(CFG_FILTER, 16'd99));
		plan.push_back(reg_row(CFG_MIN_X, 16'(0)));
		plan.push_back(reg_row(CFG_MAX_X, 16'(1919)));
		plan.push_back(known_row(OP_SAMPLE, 1'b1, 8'd99, 8'd0, 16'sd100, -16'sd32768, 1'b0));
		plan.push_back(known_row(OP_SAMPLE, 1'b1, 8'd255, 8'd0, 16'sd0, -16'sd32768, 1'b1));
		// extreme neutral, then the widest difference on both axes
		plan.push_back(known_row(OP_CALIBRATE, 1'b1, 8'd255, 8'd99, 16'sd0, -16'sd32768,
			1'b0));
		plan.push_back(tilt_row(OP_SAMPLE, 1'b1, 8'd99, 8'd255));

		// hold reset, then release at a falling edge
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			row = plan[i];
			if (row.is_write)
				write_reg(row.reg_sel, row.reg_val);
			else
				send_tilt(row.op, row.pres, row.tx, row.ty, row.known, row.kx, row.ky,
					row.km);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			// pick a gain; junk in the upper data bits must be dropped
			if (ph == 0)
				g = 127;
			else if ($urandom_range(0, 3) == 0)
				g = $urandom_range(0, 127);
			else
				g = $urandom_range(1, 12);
			write_reg(CFG_ACCEL, {9'($urandom_range(0, 511)), 7'(g)});

			pick = $urandom_range(0, 5);
			if (ph == 0 || pick == 0)
				f = 0;
			else if (pick == 1)
				f = 16383;
			else if (pick < 4)
				f = $urandom_range(0, 60);
			else if (pick == 4)
				f = $urandom_range(0, 600);
			else
				f = $urandom_range(0, 16383);
			write_reg(CFG_FILTER, {2'($urandom_range(0, 3)), 14'(f)});

			for (int ax = 0; ax < 2; ax++) begin
				if (ax == 0) begin
					lo_sel = CFG_MIN_X;
					hi_sel = CFG_MAX_X;
				end else begin
					lo_sel = CFG_MIN_Y;
					hi_sel = CFG_MAX_Y;
				end
				pick = $urandom_range(0, 3);
				if (ph == 0) begin
					lo_i = -32768;
					hi_i = 32767;
				end else if (pick < 2) begin
					// screen-like window around the origin
					lo_i = -int'($urandom_range(0, 500));
					hi_i = lo_i + int'($urandom_range(50, 4000));
				end else if (pick == 2) begin
					// inverted window
					hi_i = int'($urandom_range(0, 2000)) - 1000;
					lo_i = hi_i + int'($urandom_range(1, 1000));
				end else begin
					lo_i = int'($urandom_range(0, 65535)) - 32768;
					hi_i = int'($urandom_range(0, 65535)) - 32768;
				end
				write_reg(lo_sel, 16'(lo_i));
				write_reg(hi_sel, 16'(hi_i));
			end

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				tx = 8'($urandom);
				ty = 8'($urandom);
				// half the time stay close to the last neutral to work the deadband
				if ($urandom_range(0, 1) == 0) begin
					tx = near_x + 8'($urandom_range(0, 6)) - 8'd3;
					ty = near_y + 8'($urandom_range(0, 6)) - 8'd3;
				end
				if (pick < 8) begin
					op = OP_CALIBRATE;
					pres = (pick != 0);
					if (pres) begin
						near_x = tx;
						near_y = ty;
					end
				end else if (pick < 14) begin
					op = OP_SAMPLE;
					pres = 1'b0;
				end else begin
					op = OP_SAMPLE;
					pres = 1'b1;
				end
				send_tilt(op, pres, tx, ty, 1'b0, '0, '0, 1'b0);
			end
		end

		// drain the block and give it time to show any stray result
		settle();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
